FILE: design/osut_pkg.sv
`default_nettype none

package osut_pkg;

    // Oversampling ratio of the line and depth of the transmit queue.
    localparam int OVERSAMPLE     = 8;
    localparam int TX_QUEUE_DEPTH = 16;

    localparam int DATA_W       = 8;
    localparam int FRAME_W      = 11;
    localparam int BIT_IDX_W    = 4;
    localparam int TICK_W       = $clog2(OVERSAMPLE);
    localparam int SIDX_W       = $clog2(OVERSAMPLE + 1);
    localparam int CENTER_SHIFT = OVERSAMPLE / 2 - 2;
    localparam int HIST_W       = CENTER_SHIFT + 3;
    localparam int QPTR_W       = $clog2(TX_QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(TX_QUEUE_DEPTH + 1);

    localparam logic [BIT_IDX_W-1:0] LEN_NO_PARITY = BIT_IDX_W'(10);
    localparam logic [BIT_IDX_W-1:0] LEN_PARITY    = BIT_IDX_W'(11);
    localparam logic [2:0]           START_PATTERN = 3'b100;

    typedef enum logic [1:0] {
        PAR_NONE = 2'd0,
        PAR_EVEN = 2'd1,
        PAR_ODD  = 2'd2
    } t_parity_mode;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              error;
    } t_rx_result;

    typedef struct packed {
        logic line;
        logic full;
        logic overflow;
    } t_tx_status;

    // The unused fourth code behaves as no parity.
    function automatic logic has_parity(input logic [1:0] mode);
        return (mode == PAR_EVEN) || (mode == PAR_ODD);
    endfunction

    function automatic logic [BIT_IDX_W-1:0] frame_len(input logic [1:0] mode);
        return has_parity(mode) ? LEN_PARITY : LEN_NO_PARITY;
    endfunction

    // Parity bit to send or expect for a data byte.
    function automatic logic parity_bit(input logic [1:0] mode, input logic [DATA_W-1:0] d);
        return (^d) ^ (mode == PAR_ODD);
    endfunction

    function automatic logic majority3(input logic [2:0] v);
        return (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
    endfunction

endpackage

`default_nettype wire

FILE: design/osut_rx.sv
`default_nettype none

module osut_rx (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire [1:0]            i_parity_mode,
    input  wire                  i_rx_sample,
    output osut_pkg::t_rx_result o_result
);
    import osut_pkg::*;

    logic [HIST_W-1:0]    r_hist, n_hist;
    logic [SIDX_W-1:0]    r_sidx, n_sidx;
    logic [FRAME_W-1:0]   r_bits, n_bits;
    logic [BIT_IDX_W-1:0] r_bidx, n_bidx;
    logic                 r_active, n_active;

    logic [HIST_W-1:0]    w_hist;
    logic [FRAME_W-1:0]   w_frame;
    logic [DATA_W-1:0]    w_raw;
    logic [DATA_W-1:0]    w_data;
    logic                 w_bit;
    logic                 w_ok;

    always_comb begin
        w_hist   = {r_hist[HIST_W-2:0], i_rx_sample};
        n_hist   = w_hist;
        n_sidx   = r_sidx + SIDX_W'(1);
        n_bits   = r_bits;
        n_bidx   = r_bidx;
        n_active = r_active;
        o_result = '0;
        w_frame  = '0;
        w_raw    = '0;
        w_data   = '0;
        w_bit    = 1'b0;
        w_ok     = 1'b0;

        // A falling edge seen as 1-0-0 on an idle line opens a frame.
        if (!r_active && r_bits[0] && (w_hist[2:0] == START_PATTERN)) begin
            n_hist   = '0;
            n_bits   = '0;
            n_bidx   = '0;
            n_sidx   = SIDX_W'(3);
            n_active = 1'b1;
        end

        if (n_sidx >= SIDX_W'(OVERSAMPLE)) begin
            w_bit   = majority3(n_hist[CENTER_SHIFT +: 3]);
            w_frame = {n_bits[FRAME_W-2:0], w_bit};
            n_bits  = w_frame;
            n_hist  = '0;
            n_sidx  = '0;
            if (n_active) begin
                n_bidx = n_bidx + BIT_IDX_W'(1);
                if (n_bidx >= frame_len(i_parity_mode)) begin
                    // Bits arrive LSB first, so the byte sits reversed in the shift register.
                    w_raw = has_parity(i_parity_mode) ? w_frame[9:2] : w_frame[8:1];
                    for (int i = 0; i < DATA_W; i++) begin
                        w_data[i] = w_raw[DATA_W-1-i];
                    end
                    w_ok = (has_parity(i_parity_mode) ? !w_frame[10] : !w_frame[9]) && w_frame[0];
                    if (w_ok && has_parity(i_parity_mode)) begin
                        w_ok = (w_frame[1] == parity_bit(i_parity_mode, w_data));
                    end
                    n_bidx         = '0;
                    n_active       = 1'b0;
                    o_result.valid = w_ok;
                    o_result.data  = w_ok ? w_data : '0;
                    o_result.error = !w_ok;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '0;
            r_sidx   <= '0;
            r_bits   <= '1;
            r_bidx   <= '0;
            r_active <= 1'b0;
        end else if (i_en) begin
            r_hist   <= n_hist;
            r_sidx   <= n_sidx;
            r_bits   <= n_bits;
            r_bidx   <= n_bidx;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

FILE: design/osut_tx.sv
`default_nettype none

module osut_tx (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire [1:0]                   i_parity_mode,
    input  wire                         i_tx_push,
    input  wire [osut_pkg::DATA_W-1:0]  i_tx_byte,
    output osut_pkg::t_tx_status        o_status
);
    import osut_pkg::*;

    logic [DATA_W-1:0]    r_queue [TX_QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_head, n_head;
    logic [QPTR_W-1:0]    r_tail, n_tail;
    logic [QCNT_W-1:0]    r_count, n_count;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [BIT_IDX_W-1:0] r_bidx, n_bidx;
    logic                 r_level, n_level;

    logic                 w_push_ok;
    logic                 w_sending;
    logic [QCNT_W-1:0]    w_count_p;
    logic [DATA_W-1:0]    w_pop_byte;
    logic [FRAME_W-1:0]   w_shifted;

    always_comb begin
        w_push_ok = i_tx_push && (r_count < QCNT_W'(TX_QUEUE_DEPTH));
        w_count_p = r_count + QCNT_W'(w_push_ok);
        // An empty queue hands a byte pushed in the same tick straight through.
        w_pop_byte = (r_count == '0) ? i_tx_byte : r_queue[r_head];
        w_sending  = (r_frame != '0) && (r_bidx < frame_len(i_parity_mode));
        w_shifted  = r_frame >> r_bidx;

        n_tail  = r_tail;
        if (w_push_ok) begin
            n_tail = (r_tail == QPTR_W'(TX_QUEUE_DEPTH - 1)) ? '0 : r_tail + QPTR_W'(1);
        end
        n_head  = r_head;
        n_count = w_count_p;
        n_frame = r_frame;
        n_bidx  = r_bidx;
        n_level = r_level;
        n_tick  = r_tick + TICK_W'(1);

        if (r_tick == TICK_W'(OVERSAMPLE - 1)) begin
            n_tick = '0;
            if (w_sending) begin
                n_level = w_shifted[0];
                n_bidx  = r_bidx + BIT_IDX_W'(1);
            end else begin
                // The bit period spent here keeps the line idle between frames.
                n_frame = '0;
                n_bidx  = '0;
                if (w_count_p != '0) begin
                    if (has_parity(i_parity_mode)) begin
                        n_frame = {1'b1, parity_bit(i_parity_mode, w_pop_byte), w_pop_byte, 1'b0};
                    end else begin
                        n_frame = {2'b01, w_pop_byte, 1'b0};
                    end
                    n_head  = (r_head == QPTR_W'(TX_QUEUE_DEPTH - 1)) ? '0 : r_head + QPTR_W'(1);
                    n_count = w_count_p - QCNT_W'(1);
                end
            end
        end

        o_status.line     = n_level;
        o_status.full     = (n_count == QCNT_W'(TX_QUEUE_DEPTH));
        o_status.overflow = i_tx_push && !w_push_ok;
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_push_ok) begin
            r_queue[r_tail] <= i_tx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_tick  <= '0;
            r_frame <= '0;
            r_bidx  <= '0;
            r_level <= 1'b1;
        end else if (i_en) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_tick  <= n_tick;
            r_frame <= n_frame;
            r_bidx  <= n_bidx;
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

FILE: design/oversampled_uart_transceiver.sv
// Oversampled UART transceiver, 8 data bits, optional even or odd parity, one stop bit.
// Each transfer on the slave stream is one oversampling tick: the sampled receive line,
// a push strobe and a byte to queue for sending. Each tick yields exactly one transfer on
// the master stream carrying the transmit line level, a received byte with its valid and
// error flags, and the transmit queue status (full, and overflow for a dropped push).
// The result of a tick is registered and offered on the master stream in the cycle
// after the slave transfer. Throughput is one tick per cycle while the master side
// does not stall; all the work of a tick is shallow logic between the state registers
// and the output register, and the queue read is a single register-file port.
// The output register frees the input side: a new tick is taken while the previous
// result is taken in the same cycle. When the master side stalls with a result held,
// s_axis_tready drops and the line state waits until the result is taken.
// The parity mode register is written through the cfg channel, which is always ready;
// write it only while no tick is in flight.
// Reset (synchronous, active low) empties the queue, idles both lines high and clears
// the parity mode to no parity. Queue entries keep no reset value.
`default_nettype none

module oversampled_uart_transceiver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave stream: [0] rx_sample, [1] tx_push, [9:2] tx_byte, [15:10] zero.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,
    // Master stream: [0] tx_line, [1] rx_valid, [9:2] rx_byte, [10] rx_error,
    // [11] tx_queue_full, [12] tx_overflow, [15:13] zero.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // Configuration write channel: parity mode.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_data
);
    import osut_pkg::*;

    logic [1:0]  r_mode;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        w_accept;
    t_rx_result  w_rx;
    t_tx_status  w_tx;

    // A tick is taken whenever the output register is empty or being emptied.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PAR_NONE;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    osut_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_accept),
        .i_parity_mode (r_mode),
        .i_rx_sample   (s_axis_tdata[0]),
        .o_result      (w_rx)
    );

    osut_tx u_tx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_accept),
        .i_parity_mode (r_mode),
        .i_tx_push     (s_axis_tdata[1]),
        .i_tx_byte     (s_axis_tdata[9:2]),
        .o_status      (w_tx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The payload register only loads on an accepted tick, so a stalled result holds.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {3'b000, w_tx.overflow, w_tx.full, w_rx.error,
                           w_rx.data, w_rx.valid, w_tx.line};
        end
    end

endmodule

`default_nettype wire

FILE: design/osut_checker.sv
`default_nettype none

module osut_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);

    // A frame is either good or bad, never both.
    a_valid_xor_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[10]))
        else $error("rx_valid and rx_error both set");

    // The received byte reads as zero when no good frame completed.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[9:2] == 8'h00))
        else $error("rx_byte nonzero without rx_valid");

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind oversampled_uart_transceiver osut_checker u_osut_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
